// ===== sv/tgasd_pkg.sv =====
// ----------------------------------------------------------------------------
// tgasd_pkg
// Shared constants, palette port type and pixel conversion for the TGA decoder.
// ----------------------------------------------------------------------------
package tgasd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ST_BAD_DEPTH = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [1:0] KIND_MAPPED = 2'd1;

    // palette write port
    typedef struct packed {
        logic              en;
        logic [PAL_AW-1:0] addr;
        logic [31:0]       data;
    } t_pal_wr;

    function automatic logic [2:0] bytes_for(input logic [5:0] bits);
        logic [2:0] n;
        case (bits)
            6'd8:           n = 3'd1;
            6'd15, 6'd16:   n = 3'd2;
            6'd24:          n = 3'd3;
            default:        n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

    // packed as r, g, b, a from high to low byte
    function automatic logic [31:0] to_rgba(input logic [5:0] bits, input logic [31:0] v);
        logic [31:0] res;
        case (bits)
            6'd15, 6'd16: res = {expand5(v[14:10]), expand5(v[9:5]), expand5(v[4:0]), 8'hff};
            6'd8:         res = {v[7:0], v[7:0], v[7:0], 8'hff};
            6'd32:        res = {v[23:16], v[15:8], v[7:0], v[31:24]};
            default:      res = {v[23:16], v[15:8], v[7:0], 8'hff};
        endcase
        return res;
    endfunction

endpackage

// ===== sv/tgasd_palette.sv =====
// ----------------------------------------------------------------------------
// tgasd_palette
// Palette store: one write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module tgasd_palette
    import tgasd_pkg::*;
(
    input  logic              i_clk,
    input  t_pal_wr           i_wr,
    input  logic              i_rd_en,
    input  logic [PAL_AW-1:0] i_rd_addr,
    output logic [31:0]       o_rd_data
);

    logic [31:0] mem [PALETTE_DEPTH];
    logic [31:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/tga_stream_decoder_top.sv =====
// ----------------------------------------------------------------------------
// tga_stream_decoder_top
// Byte-serial TGA parser and pixel decoder with palette lookup.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  in      | input     | i_valid / o_stall | i_in_byte, i_file_start
//  out     | output    | o_valid / i_stall | color, repeat, last, size, status
//
//  One byte per cycle while o_stall is low; each byte is parsed combinationally,
//  then its result is registered in the palette read stage and in the output register.
//  The palette read port is read once per byte at most, so no stall is inserted.
//  Reset clears the parser; palette contents stay undefined until loaded.
//  The input stalls only when both the lookup stage and the output hold items.
// ----------------------------------------------------------------------------
module tga_stream_decoder_top
    import tgasd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_file_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_pixel,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [1:0]  o_status
);

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_ID     = 3'd1,
        PH_MAP    = 3'd2,
        PH_PIXELS = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] fc;
        logic [1:0]  kind;
        logic        rle;
        logic [5:0]  pix_bits;
        logic [5:0]  map_bits;
        logic [15:0] first;
        logic [15:0] entries;
        logic [7:0]  id_len;
        logic [15:0] width;
        logic [15:0] height;
        logic [31:0] pix_left;
        logic [7:0]  pkt_left;
        logic        is_run;
        logic [23:0] gather;
        logic [1:0]  gcount;
        logic        map_present;
    } t_parse;

    localparam logic [16:0] DEPTH_W = 17'(PALETTE_DEPTH);

    t_parse r_ps, cur, n_ps;

    logic        accept, s1_move;
    logic        res_valid, res_pal, res_last;
    logic [1:0]  res_status;
    logic [31:0] res_rgba;
    logic [7:0]  res_rep;
    logic [PAL_AW-1:0] pal_idx;
    t_pal_wr     pal_wr;
    logic [31:0] pal_data;

    logic        do_after_id, do_begin;
    logic [31:0] gshift, prod, rep_w;
    logic [16:0] map_addr;
    logic [15:0] idx;
    logic [7:0]  b;

    // lookup stage
    logic        r_s1_valid, r_s1_pal, r_s1_last;
    logic [1:0]  r_s1_status;
    logic [31:0] r_s1_rgba;
    logic [7:0]  r_s1_rep;
    logic [15:0] r_s1_w, r_s1_h;

    // output register
    logic        r_o_valid, r_o_last;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_rgba;
    logic [7:0]  r_o_rep;
    logic [15:0] r_o_w, r_o_h;

    assign s1_move = !r_o_valid || !i_stall;
    assign o_stall = r_s1_valid && !s1_move;
    assign accept  = i_valid && !o_stall;
    assign b       = i_in_byte;
    assign prod    = 32'(cur.width) * 32'(cur.height);

    always_comb begin
        cur = r_ps;
        if (i_file_start) begin
            cur = '0;
        end
        n_ps        = cur;
        res_valid   = 1'b0;
        res_pal     = 1'b0;
        res_last    = 1'b0;
        res_status  = ST_PIXEL;
        res_rgba    = '0;
        res_rep     = '0;
        pal_idx     = '0;
        pal_wr      = '0;
        do_after_id = 1'b0;
        do_begin    = 1'b0;
        map_addr    = '0;
        idx         = '0;
        rep_w       = '0;
        gshift      = {8'd0, cur.gather} | ({24'd0, b} << {cur.gcount, 3'b000});

        case (cur.phase)
            PH_HEADER: begin
                n_ps.fc = cur.fc + 16'd1;
                case (cur.fc)
                    16'd0: n_ps.id_len = b;
                    16'd1: begin
                        if (b > 8'd1) begin
                            n_ps.phase = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = ST_BAD_TYPE;
                        end else begin
                            n_ps.map_present = b[0];
                        end
                    end
                    16'd2: begin
                        if (b[7:4] != 4'd0 || b[2:0] == 3'd0 || b[2:0] > 3'd3) begin
                            n_ps.phase = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = ST_BAD_TYPE;
                        end else begin
                            n_ps.kind = b[1:0];
                            n_ps.rle  = b[3];
                        end
                    end
                    16'd3: n_ps.first[7:0]    = b;
                    16'd4: n_ps.first[15:8]   = b;
                    16'd5: n_ps.entries[7:0]  = b;
                    16'd6: n_ps.entries[15:8] = b;
                    16'd7: begin
                        if (cur.map_present) begin
                            if (b != 8'd15 && b != 8'd16 && b != 8'd24 && b != 8'd32) begin
                                n_ps.phase = PH_DONE;
                                res_valid  = 1'b1;
                                res_status = ST_BAD_DEPTH;
                            end else begin
                                n_ps.map_bits = b[5:0];
                            end
                        end
                    end
                    16'd12: n_ps.width[7:0]   = b;
                    16'd13: n_ps.width[15:8]  = b;
                    16'd14: n_ps.height[7:0]  = b;
                    16'd15: n_ps.height[15:8] = b;
                    16'd16: begin
                        if ((cur.kind == KIND_MAPPED &&
                             !(b == 8'd8 || b == 8'd15 || b == 8'd16)) ||
                            (cur.kind == 2'd2 &&
                             !(b == 8'd15 || b == 8'd16 || b == 8'd24 || b == 8'd32)) ||
                            (cur.kind != KIND_MAPPED && cur.kind != 2'd2 && b != 8'd8)) begin
                            n_ps.phase = PH_DONE;
                            res_valid  = 1'b1;
                            res_status = ST_BAD_DEPTH;
                        end else begin
                            n_ps.pix_bits = b[5:0];
                        end
                    end
                    16'd17: begin
                        n_ps.pix_left = prod;
                        n_ps.fc       = '0;
                        if (cur.id_len != 8'd0) begin
                            n_ps.phase = PH_ID;
                        end else begin
                            do_after_id = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            PH_ID: begin
                n_ps.fc = cur.fc + 16'd1;
                if (n_ps.fc >= {8'd0, cur.id_len}) begin
                    do_after_id = 1'b1;
                end
            end
            PH_MAP: begin
                if ({1'b0, cur.gcount} + 3'd1 < bytes_for(cur.map_bits)) begin
                    n_ps.gather = gshift[23:0];
                    n_ps.gcount = cur.gcount + 2'd1;
                end else begin
                    n_ps.gather = '0;
                    n_ps.gcount = '0;
                    map_addr    = {1'b0, cur.first} + {1'b0, cur.fc};
                    pal_wr.en   = (map_addr < DEPTH_W);
                    pal_wr.addr = map_addr[PAL_AW-1:0];
                    pal_wr.data = to_rgba(cur.map_bits, gshift);
                    n_ps.fc     = cur.fc + 16'd1;
                    if (n_ps.fc >= cur.entries) begin
                        do_begin = 1'b1;
                    end
                end
            end
            PH_PIXELS: begin
                if (cur.rle && cur.pkt_left == 8'd0) begin
                    n_ps.is_run   = b[7];
                    n_ps.pkt_left = {1'b0, b[6:0]} + 8'd1;
                end else if ({1'b0, cur.gcount} + 3'd1 < bytes_for(cur.pix_bits)) begin
                    n_ps.gather = gshift[23:0];
                    n_ps.gcount = cur.gcount + 2'd1;
                end else begin
                    n_ps.gather = '0;
                    n_ps.gcount = '0;
                    rep_w = 32'd1;
                    if (cur.rle && cur.is_run) begin
                        rep_w         = {24'd0, cur.pkt_left};
                        n_ps.pkt_left = '0;
                    end else if (cur.rle) begin
                        n_ps.pkt_left = cur.pkt_left - 8'd1;
                    end
                    if (rep_w > cur.pix_left) begin
                        rep_w = cur.pix_left;
                    end
                    n_ps.pix_left = cur.pix_left - rep_w;
                    res_last      = (n_ps.pix_left == 32'd0);
                    if (res_last) begin
                        n_ps.phase = PH_DONE;
                    end
                    res_valid = 1'b1;
                    res_rep   = rep_w[7:0];
                    if (cur.kind != KIND_MAPPED) begin
                        res_rgba = to_rgba(cur.pix_bits, gshift);
                    end else begin
                        case (cur.pix_bits)
                            6'd8:    idx = {8'd0, gshift[7:0]};
                            6'd15:   idx = {1'b0, gshift[14:0]};
                            default: idx = gshift[15:0];
                        endcase
                        if (idx < cur.first || (idx - cur.first) >= cur.entries ||
                            {1'b0, idx} >= DEPTH_W) begin
                            res_status = ST_RANGE;
                        end else begin
                            res_pal = 1'b1;
                            pal_idx = idx[PAL_AW-1:0];
                        end
                    end
                end
            end
            default: ;
        endcase

        if (do_after_id) begin
            if (n_ps.map_present && n_ps.entries != 16'd0) begin
                n_ps.phase  = PH_MAP;
                n_ps.fc     = '0;
                n_ps.gather = '0;
                n_ps.gcount = '0;
            end else begin
                do_begin = 1'b1;
            end
        end
        if (do_begin) begin
            n_ps.pkt_left = '0;
            n_ps.is_run   = 1'b0;
            n_ps.gather   = '0;
            n_ps.gcount   = '0;
            n_ps.phase    = (n_ps.pix_left == 32'd0) ? PH_DONE : PH_PIXELS;
        end
    end

    tgasd_palette u_palette (
        .i_clk     (i_clk),
        .i_wr      (accept ? pal_wr : t_pal_wr'('0)),
        .i_rd_en   (accept && res_pal),
        .i_rd_addr (pal_idx),
        .o_rd_data (pal_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps       <= '0;
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_ps <= n_ps;
            end
            if (accept) begin
                r_s1_valid <= res_valid;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= r_s1_valid;
            end
        end
        if (accept) begin
            r_s1_pal    <= res_pal;
            r_s1_last   <= res_last;
            r_s1_status <= res_status;
            r_s1_rgba   <= res_rgba;
            r_s1_rep    <= res_rep;
            r_s1_w      <= n_ps.width;
            r_s1_h      <= n_ps.height;
        end
        if (s1_move && r_s1_valid) begin
            r_o_rgba   <= r_s1_pal ? pal_data : r_s1_rgba;
            r_o_last   <= r_s1_last;
            r_o_status <= r_s1_status;
            r_o_rep    <= r_s1_rep;
            r_o_w      <= r_s1_w;
            r_o_h      <= r_s1_h;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_red          = r_o_rgba[31:24];
    assign o_green        = r_o_rgba[23:16];
    assign o_blue         = r_o_rgba[15:8];
    assign o_alpha        = r_o_rgba[7:0];
    assign o_repeat_count = r_o_rep;
    assign o_last_pixel   = r_o_last;
    assign o_image_width  = r_o_w;
    assign o_image_height = r_o_h;
    assign o_status       = r_o_status;

    // a held lookup item is not lost while the output is blocked
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid)
        else $error("lookup item dropped under stall");

    // header errors carry no pixel count
    a_err_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_BAD_TYPE || o_status == ST_BAD_DEPTH)
            |-> o_repeat_count == 8'd0 && !o_last_pixel)
        else $error("header error with repeat count");

    // pixel results always cover at least one pixel
    a_pix_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_PIXEL || o_status == ST_RANGE) |-> o_repeat_count != 8'd0)
        else $error("pixel result with zero repeat");

    // a finished stream yields nothing until restarted
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_ps.phase == PH_DONE && !i_file_start |=> !r_s1_valid)
        else $error("result after end of image");

    // palette is never written and read in the same accepted byte
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !(pal_wr.en && res_pal))
        else $error("palette write and read together");

endmodule
